### hdl/lrc_pkg.sv
// Package: shared types, constants and outcode function for the line clipper.
package lrc_pkg;

    localparam int COORD_BITS = 32;
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int DIV_CYCLES = PROD_BITS / 2;
    localparam int CNT_BITS   = $clog2(DIV_CYCLES);
    localparam int MAX_PASSES = 8;
    localparam int PASS_BITS  = $clog2(MAX_PASSES + 1);

    localparam logic [3:0] OC_TOP    = 4'd1;
    localparam logic [3:0] OC_BOTTOM = 4'd2;
    localparam logic [3:0] OC_RIGHT  = 4'd4;
    localparam logic [3:0] OC_LEFT   = 4'd8;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t begin_x;
        coord_t begin_y;
        coord_t end_x;
        coord_t end_y;
    } seg_t;

    typedef struct packed {
        logic   visible;
        coord_t clip_begin_x;
        coord_t clip_begin_y;
        coord_t clip_end_x;
        coord_t clip_end_y;
    } res_t;

    typedef enum logic [1:0] {
        EDGE_TOP,
        EDGE_BOTTOM,
        EDGE_RIGHT,
        EDGE_LEFT
    } edge_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_APPLY,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic mul;
        logic div;
        logic apply;
        logic finish;
        logic visible;
    } lrc_cmd_t;

    typedef struct packed {
        logic [3:0] code0;
        logic [3:0] code1;
    } lrc_status_t;

    function automatic logic [3:0] outcode(
        coord_t x,
        coord_t y,
        coord_t left,
        coord_t bottom,
        coord_t right,
        coord_t top
    );
        logic [3:0] c;
        c = '0;
        if (y > top)
            c = c | OC_TOP;
        if (y < bottom)
            c = c | OC_BOTTOM;
        if (x > right)
            c = c | OC_RIGHT;
        if (x < left)
            c = c | OC_LEFT;
        return c;
    endfunction

endpackage

### hdl/lrc_ctrl.sv
// Controller: sequences clip passes, the multiply and the divider steps.
module lrc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 seg_valid,
    output logic                 seg_stall,
    output logic                 res_valid,
    input  logic                 res_stall,
    input  lrc_pkg::lrc_status_t status,
    output lrc_pkg::lrc_cmd_t    cmd
);
    import lrc_pkg::*;

    ctrl_state_t          state_reg, state_next;
    logic [PASS_BITS-1:0] pass_reg, pass_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 res_valid_reg, res_valid_next;
    logic                 both_in, common;

    assign both_in   = (status.code0 | status.code1) == 4'd0;
    assign common    = (status.code0 & status.code1) != 4'd0;
    assign seg_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (seg_valid)
                begin
                    cmd.load   = 1'b1;
                    pass_next  = '0;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (both_in || common || pass_reg == PASS_BITS'(MAX_PASSES))
                    state_next = S_DONE;
                else
                begin
                    cmd.prep   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(DIV_CYCLES - 1))
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                pass_next  = pass_reg + 1'b1;
                state_next = S_EVAL;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!res_valid_reg || !res_stall)
                begin
                    cmd.finish  = 1'b1;
                    cmd.visible = both_in;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

endmodule

### hdl/lrc_dp.sv
// Datapath: rectangle registers, segment ends, multiplier, divider, result register.
module lrc_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  lrc_pkg::coord_t      cfg_data,
    input  lrc_pkg::seg_t        seg,
    output lrc_pkg::res_t        res,
    input  lrc_pkg::lrc_cmd_t    cmd,
    output lrc_pkg::lrc_status_t status
);
    import lrc_pkg::*;

    localparam int CW = COORD_BITS;

    typedef struct packed {
        logic [CW-1:0]        rem;
        logic [PROD_BITS-1:0] dq;
    } div_pair_t;

    coord_t rect_left_reg, rect_bottom_reg, rect_right_reg, rect_top_reg;
    coord_t px_reg [2];
    coord_t py_reg [2];

    logic [CW-1:0]        mag_a_reg, mag_b_reg, dv_reg;
    logic                 neg_reg, den_zero_reg, sel_reg;
    coord_t               base_reg;
    edge_t                edge_reg;
    div_pair_t            div_reg, div_next;
    res_t                 res_reg;

    logic [3:0]           code0, code1, sel_code;
    logic                 sel;
    edge_t                edge_sel;
    logic signed [CW:0]   dx, dy, d_op, e_op, den_op;
    coord_t               base_op;
    logic [CW+1:0]        base_ext, q_ext, sum_w;
    coord_t               newc;

    function automatic logic [CW-1:0] mag(logic signed [CW:0] v);
        logic [CW:0] a;
        a = v[CW] ? -v : v;
        return a[CW-1:0];
    endfunction

    function automatic div_pair_t div_step(div_pair_t s, logic [CW-1:0] dv);
        logic [CW:0] r;
        logic        ge;
        div_pair_t   o;
        r     = {s.rem, s.dq[PROD_BITS-1]};
        ge    = (r >= {1'b0, dv});
        o.dq  = {s.dq[PROD_BITS-2:0], ge};
        o.rem = ge ? CW'(r - {1'b0, dv}) : r[CW-1:0];
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg   <= '0;
            rect_bottom_reg <= '0;
            rect_right_reg  <= '0;
            rect_top_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT:   rect_left_reg   <= cfg_data;
                REG_BOTTOM: rect_bottom_reg <= cfg_data;
                REG_RIGHT:  rect_right_reg  <= cfg_data;
                REG_TOP:    rect_top_reg    <= cfg_data;
                default:    rect_left_reg   <= rect_left_reg;
            endcase
        end
    end

    assign code0 = outcode(px_reg[0], py_reg[0], rect_left_reg, rect_bottom_reg,
                           rect_right_reg, rect_top_reg);
    assign code1 = outcode(px_reg[1], py_reg[1], rect_left_reg, rect_bottom_reg,
                           rect_right_reg, rect_top_reg);
    assign status.code0 = code0;
    assign status.code1 = code1;

    // Pick the first outside end and the first edge it lies beyond, and form the operands for that edge.
    always_comb
    begin
        sel      = (code0 == 4'd0);
        sel_code = sel ? code1 : code0;
        if ((sel_code & OC_TOP) != 4'd0)
            edge_sel = EDGE_TOP;
        else if ((sel_code & OC_BOTTOM) != 4'd0)
            edge_sel = EDGE_BOTTOM;
        else if ((sel_code & OC_RIGHT) != 4'd0)
            edge_sel = EDGE_RIGHT;
        else
            edge_sel = EDGE_LEFT;

        dx = {px_reg[1][CW-1], px_reg[1]} - {px_reg[0][CW-1], px_reg[0]};
        dy = {py_reg[1][CW-1], py_reg[1]} - {py_reg[0][CW-1], py_reg[0]};

        unique case (edge_sel)
            EDGE_TOP:
            begin
                d_op    = dx;
                e_op    = {rect_top_reg[CW-1], rect_top_reg} - {py_reg[sel][CW-1], py_reg[sel]};
                den_op  = dy;
                base_op = px_reg[sel];
            end
            EDGE_BOTTOM:
            begin
                d_op    = dx;
                e_op    = {rect_bottom_reg[CW-1], rect_bottom_reg}
                          - {py_reg[sel][CW-1], py_reg[sel]};
                den_op  = dy;
                base_op = px_reg[sel];
            end
            EDGE_RIGHT:
            begin
                d_op    = dy;
                e_op    = {rect_right_reg[CW-1], rect_right_reg}
                          - {px_reg[sel][CW-1], px_reg[sel]};
                den_op  = dx;
                base_op = py_reg[sel];
            end
            default:
            begin
                d_op    = dy;
                e_op    = {rect_left_reg[CW-1], rect_left_reg} - {px_reg[sel][CW-1], px_reg[sel]};
                den_op  = dx;
                base_op = py_reg[sel];
            end
        endcase
    end

    always_comb
    begin
        div_next = div_step(div_step(div_reg, dv_reg), dv_reg);
    end

    // Quotient never exceeds the span between the ends, so its low bits suffice.
    assign base_ext = {{2{base_reg[CW-1]}}, base_reg};
    assign q_ext    = {1'b0, div_reg.dq[CW:0]};
    assign sum_w    = neg_reg ? (base_ext - q_ext) : (base_ext + q_ext);
    assign newc     = den_zero_reg ? base_reg : sum_w[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg[0] <= seg.begin_x;
            py_reg[0] <= seg.begin_y;
            px_reg[1] <= seg.end_x;
            py_reg[1] <= seg.end_y;
        end
        else if (cmd.apply)
        begin
            unique case (edge_reg)
                EDGE_TOP:
                begin
                    px_reg[sel_reg] <= newc;
                    py_reg[sel_reg] <= rect_top_reg;
                end
                EDGE_BOTTOM:
                begin
                    px_reg[sel_reg] <= newc;
                    py_reg[sel_reg] <= rect_bottom_reg;
                end
                EDGE_RIGHT:
                begin
                    py_reg[sel_reg] <= newc;
                    px_reg[sel_reg] <= rect_right_reg;
                end
                default:
                begin
                    py_reg[sel_reg] <= newc;
                    px_reg[sel_reg] <= rect_left_reg;
                end
            endcase
        end

        if (cmd.prep)
        begin
            mag_a_reg    <= mag(d_op);
            mag_b_reg    <= mag(e_op);
            dv_reg       <= mag(den_op);
            neg_reg      <= d_op[CW] ^ e_op[CW] ^ den_op[CW];
            den_zero_reg <= (den_op == '0);
            base_reg     <= base_op;
            edge_reg     <= edge_sel;
            sel_reg      <= sel;
        end

        if (cmd.mul)
        begin
            div_reg.rem <= '0;
            div_reg.dq  <= PROD_BITS'(mag_a_reg) * PROD_BITS'(mag_b_reg);
        end
        else if (cmd.div)
            div_reg <= div_next;

        if (cmd.finish)
        begin
            res_reg.visible <= cmd.visible;
            if (cmd.visible)
            begin
                res_reg.clip_begin_x <= px_reg[0];
                res_reg.clip_begin_y <= py_reg[0];
                res_reg.clip_end_x   <= px_reg[1];
                res_reg.clip_end_y   <= py_reg[1];
            end
            else
            begin
                res_reg.clip_begin_x <= '0;
                res_reg.clip_begin_y <= '0;
                res_reg.clip_end_x   <= '0;
                res_reg.clip_end_y   <= '0;
            end
        end
    end

    assign res = res_reg;

endmodule

### hdl/line_rect_clipper_core.sv
// Top level: Cohen-Sutherland segment clipper against a configured rectangle.
// Usage:
//   cfg channel   - write rect_left (0), rect_bottom (1), rect_right (2) and
//                   rect_top (3) as signed Q16.16; cfg_ready is always high.
//                   Write only while no segment is in flight.
//   seg channel   - one request per segment; taken when seg_valid is high and
//                   seg_stall is low. seg_stall is high while a segment is in work.
//   res channel   - one result per segment: visible flag and the clipped ends,
//                   or all zeros when the segment is rejected.
// Timing: each edge move is one pass: decide, one 32x32 multiply, the
//   two-bit-per-cycle restoring divider, and the update. A segment reaches
//   the result register after P passes, with P the number of edge moves
//   (0 to 8, usually at most 4); the next segment is taken only once that
//   result is written. The divider takes most of each pass.
// Reset: rst_n clears the rectangle to zero and empties the result register.
// Stall: a result waits in its register while res_stall is high; the next
//   segment is accepted and worked on meanwhile, and holds before writing its
//   result until the register is taken.
module line_rect_clipper_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  lrc_pkg::coord_t cfg_data,
    input  logic            seg_valid,
    output logic            seg_stall,
    input  lrc_pkg::seg_t   seg,
    output logic            res_valid,
    input  logic            res_stall,
    output lrc_pkg::res_t   res
);
    import lrc_pkg::*;

    lrc_cmd_t    cmd;
    lrc_status_t status;

    // Config writes are always taken; the block is idle by contract.
    assign cfg_ready = 1'b1;

    lrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lrc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seg       (seg),
        .res       (res),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Testbench: checks the segment clipper against its own predictor under random flow control.
module tb_top;
    import lrc_pkg::*;

    // Slowest segment: the full MAX_PASSES edge moves plus the accept, the final check and the finish.
    // The long settle at the end adds margin past that.
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int DRAIN_CYCLES = 3 + 35 * MAX_PASSES + 20;
    localparam int IDLE_PCT     = 27;

    localparam coord_t C_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
    localparam coord_t C_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};

    // Predicts each clipped segment and holds the results still owed by the block.
    // It keeps its own copy of the rectangle, updated on every register write.
    class clip_ledger;
        longint left;
        longint bottom;
        longint right;
        longint top;
        res_t   awaited[$];
        int     mismatches;
        int     clips_seen;
        int     visible_seen;

        function new();
            left = 0;
            bottom = 0;
            right = 0;
            top = 0;
            mismatches = 0;
            clips_seen = 0;
            visible_seen = 0;
        endfunction

        function void set_rect(logic [1:0] idx, coord_t value);
            case (idx)
                REG_LEFT:   left = value;
                REG_BOTTOM: bottom = value;
                REG_RIGHT:  right = value;
                default:    top = value;
            endcase
        endfunction

        // Outcode bits: strictly beyond each edge.
        function logic [3:0] region(longint x, longint y);
            logic [3:0] c;
            c = '0;
            if (y > top)
                c = c | OC_TOP;
            if (y < bottom)
                c = c | OC_BOTTOM;
            if (x > right)
                c = c | OC_RIGHT;
            if (x < left)
                c = c | OC_LEFT;
            return c;
        endfunction

        // base + d * e / den, quotient truncated toward zero; full-width product.
        function longint slide(longint base, longint d, longint e, longint den);
            logic [127:0] prod;
            logic [127:0] quo;
            logic [63:0]  a;
            logic [63:0]  b;
            logic [63:0]  dv;
            longint       step;
            bit           neg;
            if (den == 0)
                return base;
            a = (d < 0) ? -d : d;
            b = (e < 0) ? -e : e;
            dv = (den < 0) ? -den : den;
            prod = {64'd0, a} * {64'd0, b};
            quo = prod / {64'd0, dv};
            step = longint'(quo[63:0]);
            neg = ((d < 0) != (e < 0)) != (den < 0);
            return neg ? base - step : base + step;
        endfunction

        function res_t clip_segment(seg_t s);
            longint     px[2];
            longint     py[2];
            logic [3:0] code[2];
            longint     dx;
            longint     dy;
            int         k;
            bit         ok;
            res_t       out;
            px[0] = s.begin_x;
            py[0] = s.begin_y;
            px[1] = s.end_x;
            py[1] = s.end_y;
            code[0] = region(px[0], py[0]);
            code[1] = region(px[1], py[1]);
            ok = 0;
            for (int pass = 0; pass <= MAX_PASSES; pass++)
            begin
                if (code[0] == 0 && code[1] == 0)
                begin
                    ok = 1;
                    break;
                end
                // A shared outside bit, or too many moves, rejects the segment.
                if ((code[0] & code[1]) != 0 || pass == MAX_PASSES)
                    break;
                k = (code[0] != 0) ? 0 : 1;
                dx = px[1] - px[0];
                dy = py[1] - py[0];
                if ((code[k] & OC_TOP) != 0)
                begin
                    px[k] = slide(px[k], dx, top - py[k], dy);
                    py[k] = top;
                end
                else if ((code[k] & OC_BOTTOM) != 0)
                begin
                    px[k] = slide(px[k], dx, bottom - py[k], dy);
                    py[k] = bottom;
                end
                else if ((code[k] & OC_RIGHT) != 0)
                begin
                    py[k] = slide(py[k], dy, right - px[k], dx);
                    px[k] = right;
                end
                else
                begin
                    py[k] = slide(py[k], dy, left - px[k], dx);
                    px[k] = left;
                end
                code[k] = region(px[k], py[k]);
            end
            out = '0;
            if (ok)
            begin
                out.visible = 1'b1;
                out.clip_begin_x = coord_t'(px[0]);
                out.clip_begin_y = coord_t'(py[0]);
                out.clip_end_x = coord_t'(px[1]);
                out.clip_end_y = coord_t'(py[1]);
            end
            return out;
        endfunction

        function void note_segment(seg_t s);
            awaited.push_back(clip_segment(s));
        endfunction

        function void report(string field, logic signed [63:0] want,
                             logic signed [63:0] got);
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        endfunction

        function void check_clip(res_t got);
            res_t want;
            clips_seen++;
            if (awaited.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing expected: %h", $time, got);
                return;
            end
            want = awaited.pop_front();
            if (want.visible)
                visible_seen++;
            if (got.visible !== want.visible)
                report("visible", want.visible, got.visible);
            if (got.clip_begin_x !== want.clip_begin_x)
                report("clip_begin_x", want.clip_begin_x, got.clip_begin_x);
            if (got.clip_begin_y !== want.clip_begin_y)
                report("clip_begin_y", want.clip_begin_y, got.clip_begin_y);
            if (got.clip_end_x !== want.clip_end_x)
                report("clip_end_x", want.clip_end_x, got.clip_end_x);
            if (got.clip_end_y !== want.clip_end_y)
                report("clip_end_y", want.clip_end_y, got.clip_end_y);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    coord_t      cfg_data;
    logic        seg_valid;
    logic        seg_stall;
    seg_t        seg;
    logic        res_valid;
    logic        res_stall;
    res_t        res;

    clip_ledger  ledger;
    bit          steady;          // suppress all idling on both sides
    int unsigned cycles;
    int          segments_sent;
    int          settings_run;
    coord_t      rect_now[4];     // rectangle as last written, for stimulus shaping
    coord_t      ra;
    coord_t      rb;
    coord_t      rc;
    coord_t      rd;

    line_rect_clipper_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop: count cycles and give up well past the slowest correct run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: stall at random on the falling edge, take results on the rising edge.
    always @(negedge clk)
        res_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            ledger.check_clip(res);

    // Write one rectangle register; hold the request until ready.
    task automatic write_reg(logic [1:0] idx, coord_t value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ledger.set_rect(idx, value);
        rect_now[idx] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_rect(coord_t l, coord_t b, coord_t r, coord_t t);
        write_reg(REG_LEFT, l);
        write_reg(REG_BOTTOM, b);
        write_reg(REG_RIGHT, r);
        write_reg(REG_TOP, t);
        settings_run++;
    endtask

    // Offer one segment request, with random gaps in front; hold it while stalled.
    task automatic send_segment(seg_t s);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            seg_valid <= 1'b0;
            @(negedge clk);
        end
        seg_valid <= 1'b1;
        seg <= s;
        @(posedge clk);
        while (seg_stall)
            @(posedge clk);
        ledger.note_segment(s);
        segments_sent++;
    endtask

    // Drop valid, wait until every expected result is in, then wait out the given extra cycles.
    task automatic settle(int extra);
        @(negedge clk);
        seg_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    function automatic coord_t q16(int whole);
        return coord_t'(whole) <<< 16;
    endfunction

    function automatic seg_t span(coord_t bx, coord_t by, coord_t ex, coord_t ey);
        seg_t s;
        s.begin_x = bx;
        s.begin_y = by;
        s.end_x = ex;
        s.end_y = ey;
        return s;
    endfunction

    // Pick one coordinate: mostly around the rectangle's span on this axis, some
    // right on or next to an edge, some anywhere in the full range.
    function automatic coord_t pick_axis(coord_t e0, coord_t e1);
        longint lo;
        longint hi;
        longint w;
        longint v;
        lo = (e0 < e1) ? e0 : e1;
        hi = (e0 < e1) ? e1 : e0;
        w = hi - lo + 16;
        case ($urandom_range(0, 9))
            0: v = coord_t'($urandom);
            1: v = lo + int'($urandom_range(0, 2)) - 1;
            2: v = hi + int'($urandom_range(0, 2)) - 1;
            default: v = lo - w + longint'({$urandom, $urandom} % (3 * w + 1));
        endcase
        if (v < longint'(C_MIN))
            v = C_MIN;
        if (v > longint'(C_MAX))
            v = C_MAX;
        return coord_t'(v);
    endfunction

    function automatic seg_t random_segment();
        seg_t s;
        s.begin_x = pick_axis(rect_now[REG_LEFT], rect_now[REG_RIGHT]);
        s.begin_y = pick_axis(rect_now[REG_BOTTOM], rect_now[REG_TOP]);
        s.end_x = pick_axis(rect_now[REG_LEFT], rect_now[REG_RIGHT]);
        s.end_y = pick_axis(rect_now[REG_BOTTOM], rect_now[REG_TOP]);
        // Occasionally collapse the segment to a single point.
        if ($urandom_range(0, 19) == 0)
        begin
            s.end_x = s.begin_x;
            s.end_y = s.begin_y;
        end
        return s;
    endfunction

    task automatic run_random(int count);
        repeat (count) send_segment(random_segment());
    endtask

    initial
    begin
        // Drive every input to a known value from time zero.
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_LEFT;
        cfg_data = '0;
        seg_valid = 1'b0;
        seg = '0;
        res_stall = 1'b0;
        steady = 1'b0;
        cycles = 0;
        segments_sent = 0;
        settings_run = 1;
        for (int i = 0; i < 4; i++)
            rect_now[i] = '0;
        ledger = new();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset rectangle: a single point at the origin.
        run_random(60);
        settle(4);

        // Ordinary rectangle [-10,10] x [-5,5]: directed cases first.
        set_rect(q16(-10), q16(-5), q16(10), q16(5));
        send_segment(span(q16(-1), q16(-1), q16(2), q16(3)));     // wholly inside
        send_segment(span(q16(-3), q16(6), q16(4), q16(9)));      // both above: reject
        send_segment(span(q16(-20), q16(0), q16(-11), q16(3)));   // both left: reject
        send_segment(span(q16(0), q16(0), q16(3), q16(12)));      // crosses top
        send_segment(span(q16(1), q16(0), q16(-2), q16(-12)));    // crosses bottom
        send_segment(span(q16(0), q16(1), q16(30), q16(4)));      // crosses right
        send_segment(span(q16(0), q16(-1), q16(-25), q16(2)));    // crosses left
        send_segment(span(q16(-20), q16(-8), q16(20), q16(8)));   // both ends outside, through
        send_segment(span(q16(5), q16(9), q16(15), q16(2)));      // misses the corner
        send_segment(span(q16(10), q16(5), q16(-10), q16(-5)));   // corner to corner on edges
        send_segment(span(q16(12), q16(0), q16(12), q16(0)));     // point outside
        send_segment(span(q16(2), q16(2), q16(2), q16(2)));       // point inside
        send_segment(span(q16(3), q16(-30), q16(3), q16(30)));    // vertical through both
        send_segment(span(q16(-40), q16(1), q16(40), q16(1)));    // horizontal through both
        send_segment(span(C_MIN, C_MIN, C_MAX, C_MAX));           // full-range diagonal
        send_segment(span(C_MAX, C_MIN, C_MIN, C_MAX));
        send_segment(span(C_MIN, '0, C_MAX, '0));
        send_segment(span('0, C_MAX, '0, C_MIN));
        send_segment(span('0, '0, -32'sd1, -32'sd1));
        send_segment(span(q16(-20) + 32'sh1234, 32'sh8001, q16(15) + 32'shABCD, -32'sh7FFF));
        send_segment(span(q16(-11), q16(4), q16(-9), q16(7)));    // misses the top-left corner
        run_random(500);
        settle(4);

        // Full-range rectangle: everything stays visible.
        set_rect(C_MIN, C_MIN, C_MAX, C_MAX);
        run_random(200);
        settle(4);

        // Random ordered rectangle, with no idling on either side.
        ra = $urandom;
        rb = $urandom;
        rc = $urandom;
        rd = $urandom;
        steady = 1'b1;
        set_rect((ra < rb) ? ra : rb, (rc < rd) ? rc : rd, (ra < rb) ? rb : ra,
                 (rc < rd) ? rd : rc);
        run_random(400);
        settle(4);
        steady = 1'b0;

        // Inverted rectangle: left above right and bottom above top.
        set_rect(q16(10), q16(5), q16(-10), q16(-5));
        run_random(150);
        settle(4);

        // Tiny rectangle with fractional edges.
        set_rect(32'sh0000_8000, -32'sh0000_3000, 32'sh0001_2000, 32'sh0000_0100);
        run_random(300);
        settle(4);

        // Fully random register values, any order.
        set_rect(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom));
        run_random(250);

        // Drain, then watch for stray results for a full segment's latency.
        settle(DRAIN_CYCLES);

        $display("Clipped %0d segments under %0d rectangle settings in %0d cycles;",
                 segments_sent, settings_run, cycles);
        $display("%0d results checked, %0d visible and %0d rejected.",
                 ledger.clips_seen, ledger.visible_seen,
                 ledger.clips_seen - ledger.visible_seen);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
hdl/lrc_pkg.sv
hdl/lrc_ctrl.sv
hdl/lrc_dp.sv
hdl/line_rect_clipper_core.sv
test/tb_top.sv
